/* rtl/efr_pkg.sv */
// Shared types and constants for the escaped frame receiver.
// Depends on nothing; used by efr_step and escaped_frame_receiver.
package efr_pkg;

   // Framing marker (DLE).
   localparam logic [7:0] MARKER = 8'h10;

   // Beat kinds on the request channel.
   localparam logic KIND_BYTE    = 1'b0;
   localparam logic KIND_TIMEOUT = 1'b1;

   typedef enum logic [1:0] {
      EV_NONE     = 2'd0,
      EV_COMPLETE = 2'd1,
      EV_DROPPED  = 2'd2
   } frame_event_type;

   typedef struct packed {
      frame_event_type frame_event;
      logic [7:0]      frame_length;
      logic            write_enable;
      logic [6:0]      write_position;
      logic [7:0]      write_value;
      logic            restart;
   } result_type;

endpackage

/* rtl/efr_step.sv */
// Framing state machine of the escaped frame receiver: mode and fill count,
// plus the one-beat result logic. Depends on efr_pkg.
module efr_step #(
   parameter int BUFFER_DEPTH = 128
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               step_en,
   input  logic               kind,
   input  logic [7:0]         byte_value,
   output efr_pkg::result_type result
);

   localparam int CountWidth = $clog2(BUFFER_DEPTH + 1);
   localparam logic [CountWidth-1:0] DepthCount = CountWidth'(BUFFER_DEPTH);

   typedef enum logic [1:0] {
      MODE_WAITING  = 2'd0,
      MODE_ESCAPING = 2'd1,
      MODE_READING  = 2'd2
   } mode_type;

   mode_type              mode_ff, mode_in;
   logic [CountWidth-1:0] fill_count_ff, fill_count_in;
   logic                  is_marker;
   logic                  has_room;
   logic [31:0]           fill_wide;

   assign is_marker = (byte_value == efr_pkg::MARKER);
   assign has_room  = (fill_count_ff < DepthCount);
   assign fill_wide = 32'(fill_count_ff);

   always_comb begin
      mode_in       = mode_ff;
      fill_count_in = fill_count_ff;
      result        = '0;
      if (kind == efr_pkg::KIND_TIMEOUT) begin
         // A timeout closes a frame only when it holds bytes and has not overflowed.
         if ((mode_ff == MODE_ESCAPING || mode_ff == MODE_READING) &&
             fill_count_ff != '0 && has_room) begin
            result.frame_event  = efr_pkg::EV_COMPLETE;
            result.frame_length = fill_wide[7:0];
            fill_count_in       = '0;
            mode_in             = MODE_WAITING;
         end
      end else begin
         case (mode_ff)
            MODE_ESCAPING: begin
               if (is_marker) begin
                  if (has_room) begin
                     result.write_enable   = 1'b1;
                     result.write_position = fill_wide[6:0];
                     result.write_value    = byte_value;
                     fill_count_in         = fill_count_ff + 1'b1;
                  end
               end else begin
                  if (fill_count_ff != '0) begin
                     result.frame_event  = has_room ? efr_pkg::EV_COMPLETE
                                                    : efr_pkg::EV_DROPPED;
                     result.frame_length = fill_wide[7:0];
                  end
                  fill_count_in         = CountWidth'(2);
                  result.write_enable   = 1'b1;
                  result.write_position = 7'd1;
                  result.write_value    = byte_value;
                  result.restart        = 1'b1;
               end
               mode_in = MODE_READING;
            end
            MODE_READING: begin
               if (is_marker) begin
                  mode_in = MODE_ESCAPING;
               end else if (has_room) begin
                  result.write_enable   = 1'b1;
                  result.write_position = fill_wide[6:0];
                  result.write_value    = byte_value;
                  fill_count_in         = fill_count_ff + 1'b1;
               end
            end
            default: begin
               // Waiting, and the unused code that behaves as waiting.
               if (is_marker) begin
                  mode_in = MODE_ESCAPING;
               end else begin
                  mode_in = MODE_WAITING;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_WAITING;
         fill_count_ff <= '0;
      end else if (step_en) begin
         mode_ff       <= mode_in;
         fill_count_ff <= fill_count_in;
      end
   end

   a_fill_bounded: assert property (@(posedge clock) disable iff (reset)
      fill_count_ff <= DepthCount)
      else $error("fill count ran past the buffer depth");

   a_restart_writes_one: assert property (@(posedge clock) disable iff (reset)
      step_en && result.restart |-> result.write_enable && result.write_position == 7'd1)
      else $error("frame restart without a store at position one");

   a_drop_on_restart: assert property (@(posedge clock) disable iff (reset)
      step_en && result.frame_event == efr_pkg::EV_DROPPED |-> result.restart)
      else $error("dropped frame reported outside a frame start");

   a_timeout_clears: assert property (@(posedge clock) disable iff (reset)
      step_en && kind == efr_pkg::KIND_TIMEOUT &&
      result.frame_event == efr_pkg::EV_COMPLETE
      |=> mode_ff == MODE_WAITING && fill_count_ff == '0)
      else $error("timeout completion did not return to waiting");

endmodule

/* rtl/escaped_frame_receiver.sv */
// Top level of the escaped frame receiver: request register, framing state
// machine (efr_step) and result register. Depends on efr_pkg and efr_step.
//
// Channel  Direction  Beat contents
// req_     in         kind (byte or timeout), byte_value
// rsp_     out        frame_event, frame_length, write_enable, write_position,
//                     write_value, restart
//
// Every request beat yields exactly one response beat, through the request register
// and then the response register. One beat is taken per cycle if rsp_ is not stalled.
// The request register and the response register each hold one beat, so a new
// request is taken while a finished response still waits for rsp_ready.
// Reset (synchronous, active high) empties both registers and puts the framing
// state machine back to waiting for a header with an empty buffer.
module escaped_frame_receiver #(
   parameter int BUFFER_DEPTH = 128
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_kind,
   input  logic [7:0] req_byte_value,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_frame_event,
   output logic [7:0] rsp_frame_length,
   output logic       rsp_write_enable,
   output logic [6:0] rsp_write_position,
   output logic [7:0] rsp_write_value,
   output logic       rsp_restart
);

   // Request register: holds the beat waiting for its turn in the state machine.
   logic       req_valid_ff;
   logic       req_kind_ff;
   logic [7:0] req_byte_ff;

   // Response register.
   logic                rsp_valid_ff;
   efr_pkg::result_type rsp_result_ff;
   efr_pkg::result_type step_result;

   // The held request moves on when the response register is free or being
   // emptied in this same cycle; the state machine advances exactly then.
   logic advance;
   assign advance   = req_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !req_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_ready) begin
         req_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_kind_ff <= req_kind;
         req_byte_ff <= req_byte_value;
      end
   end

   efr_step #(
      .BUFFER_DEPTH(BUFFER_DEPTH)
   ) u_step (
      .clock      (clock),
      .reset      (reset),
      .step_en    (advance),
      .kind       (req_kind_ff),
      .byte_value (req_byte_ff),
      .result     (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_result_ff <= step_result;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_frame_event    = rsp_result_ff.frame_event;
   assign rsp_frame_length   = rsp_result_ff.frame_length;
   assign rsp_write_enable   = rsp_result_ff.write_enable;
   assign rsp_write_position = rsp_result_ff.write_position;
   assign rsp_write_value    = rsp_result_ff.write_value;
   assign rsp_restart        = rsp_result_ff.restart;

endmodule
